// ----- rtl/ps2m_pkg.sv -----
// ============================================================================
// ps2m_pkg
// Shared types and constants for the PS/2 mouse packet cursor tracker.
// ============================================================================
package ps2m_pkg;

   // Configuration register indexes.
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 8;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ENABLE = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_X_MAX  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_Y_MAX  = 2'd2;

   // Reset values of the configuration and the cursor.
   localparam logic [7:0] X_MAX_RESET = 8'd79;
   localparam logic [7:0] Y_MAX_RESET = 8'd24;
   localparam logic [7:0] POS_X_RESET = 8'd40;
   localparam logic [7:0] POS_Y_RESET = 8'd12;

   // Header byte bit positions.
   localparam int HDR_ALWAYS_ONE = 3;
   localparam int HDR_X_SIGN     = 4;
   localparam int HDR_Y_SIGN     = 5;

   // Packet byte expected next.
   typedef enum logic [2:0] {
      PHASE_HEADER = 3'b001,
      PHASE_X      = 3'b010,
      PHASE_Y      = 3'b100
   } phase_type;

   // Configuration register contents.
   typedef struct packed {
      logic       enable;
      logic [7:0] x_max;
      logic [7:0] y_max;
   } cfg_type;

   // One result transaction.
   typedef struct packed {
      logic [7:0] cursor_x;
      logic [7:0] cursor_y;
      logic [2:0] buttons;
   } rsp_type;

endpackage

// ----- rtl/ps2m_if.sv -----
// ============================================================================
// ps2m_req_if / ps2m_rsp_if
// Valid/ready channels for mouse bytes and for cursor results.
// ============================================================================
interface ps2m_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface ps2m_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] cursor_x;
   logic [7:0] cursor_y;
   logic [2:0] buttons;

   modport source (output valid, output cursor_x, output cursor_y, output buttons,
                   input ready);
   modport sink   (input valid, input cursor_x, input cursor_y, input buttons,
                   output ready);
endinterface

// ----- rtl/ps2_mouse_packet_cursor_tracker.sv -----
// ============================================================================
// ps2_mouse_packet_cursor_tracker
// Decodes 3-byte PS/2 mouse packets into a clamped cursor and button state.
// ============================================================================
// Path: a result is registered after its third byte passes the input register and the decode stage.
// Throughput: one byte per cycle, set by the single decode stage between the
// input register and the result register; it stalls only on rsp back-pressure.
// Reset: synchronous; clears the pipeline, disables decoding, restores limits
// 79/24 and the cursor to column 40, row 12.
module ps2_mouse_packet_cursor_tracker #(
   parameter int MOTION_DIVISOR = 3
) (
   input  logic                                   clock,
   input  logic                                   reset,
   ps2m_req_if.sink                               req_port,
   ps2m_rsp_if.source                             rsp_port,
   input  logic                                   csr_we,
   input  logic [ps2m_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [ps2m_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   ps2m_pkg::cfg_type cfg_ff, cfg_in;
   logic              stage_valid_ff, stage_valid_in;
   logic [7:0]        stage_byte_ff;
   logic              out_valid_ff, out_valid_in;
   ps2m_pkg::rsp_type out_data_ff;
   logic              advance;
   logic              req_take;
   logic              res_valid;
   ps2m_pkg::rsp_type res;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            ps2m_pkg::CSR_ENABLE: cfg_in.enable = csr_wdata[0];
            ps2m_pkg::CSR_X_MAX:  cfg_in.x_max  = csr_wdata[7:0];
            ps2m_pkg::CSR_Y_MAX:  cfg_in.y_max  = csr_wdata[7:0];
            default:              cfg_in        = cfg_ff;
         endcase
      end
   end

   // The decode stage moves whenever the result register can take its output.
   assign advance          = !out_valid_ff || rsp_port.ready;
   assign req_port.ready   = !stage_valid_ff || advance;
   assign req_take         = req_port.valid && req_port.ready;
   assign stage_valid_in   = req_take ? 1'b1 : (advance ? 1'b0 : stage_valid_ff);
   assign out_valid_in     = advance ? (stage_valid_ff && res_valid) : out_valid_ff;

   ps2m_core #(
      .MOTION_DIVISOR (MOTION_DIVISOR)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .byte_valid (stage_valid_ff && advance),
      .byte_data  (stage_byte_ff),
      .res_valid  (res_valid),
      .res        (res)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable  <= 1'b0;
         cfg_ff.x_max   <= ps2m_pkg::X_MAX_RESET;
         cfg_ff.y_max   <= ps2m_pkg::Y_MAX_RESET;
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         cfg_ff         <= cfg_in;
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_byte_ff <= req_port.data_byte;
      end
      if (advance && res_valid) begin
         out_data_ff <= res;
      end
   end

   assign rsp_port.valid    = out_valid_ff;
   assign rsp_port.cursor_x = out_data_ff.cursor_x;
   assign rsp_port.cursor_y = out_data_ff.cursor_y;
   assign rsp_port.buttons  = out_data_ff.buttons;

endmodule

// ----- rtl/ps2m_core.sv -----
// ============================================================================
// ps2m_core
// Packet framing, motion scaling and cursor clamping for one byte per cycle.
// ============================================================================
module ps2m_core #(
   parameter int MOTION_DIVISOR = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  ps2m_pkg::cfg_type cfg,
   input  logic             byte_valid,
   input  logic [7:0]       byte_data,
   output logic             res_valid,
   output ps2m_pkg::rsp_type res
);

   // Reciprocal for the constant division; exact for magnitudes up to 256.
   localparam int         SHIFT = 16;
   localparam int         PROD_WIDTH = 26;
   localparam logic [16:0] RECIP =
      17'(((1 << SHIFT) + MOTION_DIVISOR - 1) / MOTION_DIVISOR);

   ps2m_pkg::phase_type phase_ff, phase_in;
   logic [7:0]          header_ff, header_in;
   logic [7:0]          x_byte_ff, x_byte_in;
   logic [7:0]          pos_x_ff, pos_x_in;
   logic [7:0]          pos_y_ff, pos_y_in;

   logic [8:0]            mag_x, mag_y;
   logic [PROD_WIDTH-1:0] prod_x, prod_y;
   logic [8:0]            quo_x, quo_y;
   logic signed [10:0]    sum_x, sum_y;

   // Clamp a full-precision position to 0..limit.
   function automatic logic [7:0] clamp_pos(logic signed [10:0] v, logic [7:0] limit);
      logic [7:0] r;
      if (v < 0) begin
         r = 8'd0;
      end else if (v > $signed({3'b000, limit})) begin
         r = limit;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

   // Magnitudes of the 9-bit movements, divided by the reciprocal multiply.
   always_comb begin
      mag_x  = header_ff[ps2m_pkg::HDR_X_SIGN] ? 9'(9'd256 - {1'b0, x_byte_ff})
                                               : {1'b0, x_byte_ff};
      mag_y  = header_ff[ps2m_pkg::HDR_Y_SIGN] ? 9'(9'd256 - {1'b0, byte_data})
                                               : {1'b0, byte_data};
      prod_x = PROD_WIDTH'(mag_x) * PROD_WIDTH'(RECIP);
      prod_y = PROD_WIDTH'(mag_y) * PROD_WIDTH'(RECIP);
      quo_x  = prod_x[SHIFT +: 9];
      quo_y  = prod_y[SHIFT +: 9];
   end

   // Apply the truncated quotients: X adds, Y subtracts.
   always_comb begin
      if (header_ff[ps2m_pkg::HDR_X_SIGN]) begin
         sum_x = $signed({3'b000, pos_x_ff}) - $signed({2'b00, quo_x});
      end else begin
         sum_x = $signed({3'b000, pos_x_ff}) + $signed({2'b00, quo_x});
      end
      if (header_ff[ps2m_pkg::HDR_Y_SIGN]) begin
         sum_y = $signed({3'b000, pos_y_ff}) + $signed({2'b00, quo_y});
      end else begin
         sum_y = $signed({3'b000, pos_y_ff}) - $signed({2'b00, quo_y});
      end
   end

   // Packet framing and state update.
   always_comb begin
      phase_in     = phase_ff;
      header_in    = header_ff;
      x_byte_in    = x_byte_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      res_valid    = 1'b0;
      res.cursor_x = clamp_pos(sum_x, cfg.x_max);
      res.cursor_y = clamp_pos(sum_y, cfg.y_max);
      res.buttons  = header_ff[2:0];
      if (byte_valid && cfg.enable) begin
         case (phase_ff)
            ps2m_pkg::PHASE_X: begin
               x_byte_in = byte_data;
               phase_in  = ps2m_pkg::PHASE_Y;
            end
            ps2m_pkg::PHASE_Y: begin
               pos_x_in  = res.cursor_x;
               pos_y_in  = res.cursor_y;
               res_valid = 1'b1;
               phase_in  = ps2m_pkg::PHASE_HEADER;
            end
            default: begin
               // Drop bytes without the always-one bit to resynchronize.
               phase_in = ps2m_pkg::PHASE_HEADER;
               if (byte_data[ps2m_pkg::HDR_ALWAYS_ONE]) begin
                  header_in = byte_data;
                  phase_in  = ps2m_pkg::PHASE_X;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= ps2m_pkg::PHASE_HEADER;
         header_ff <= 8'd0;
         x_byte_ff <= 8'd0;
         pos_x_ff  <= ps2m_pkg::POS_X_RESET;
         pos_y_ff  <= ps2m_pkg::POS_Y_RESET;
      end else begin
         phase_ff  <= phase_in;
         header_ff <= header_in;
         x_byte_ff <= x_byte_in;
         pos_x_ff  <= pos_x_in;
         pos_y_ff  <= pos_y_in;
      end
   end

endmodule

// ----- tb/sv/ps2_mouse_packet_cursor_tracker_tb.sv -----
// ============================================================================
// ps2_mouse_packet_cursor_tracker_tb
// Self-checking testbench for the PS/2 mouse packet cursor tracker. Mouse
// bytes go in through the request channel in random bursts. A packet tracker
// inside the bench follows the packet phase, the cursor and the buttons and
// predicts every cursor transaction. Directed tests cover the special cases,
// then random packet traffic runs under several limit settings. One long
// receiver hold-off fills the block so that it stalls its input.
// ============================================================================
module ps2_mouse_packet_cursor_tracker_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MOTION_DIV    = 3;
   localparam int SETTLE_CYCLES = 4;
   localparam int LONG_HOLD     = 300;
   localparam int CYCLE_LIMIT   = 400000;

   logic clock;
   logic reset;
   logic csr_we;
   logic [ps2m_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [ps2m_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata;

   ps2m_req_if req_if();
   ps2m_rsp_if rsp_if();

   ps2_mouse_packet_cursor_tracker #(
      .MOTION_DIVISOR (MOTION_DIV)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_if),
      .rsp_port  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Copy of the limits and enable as last written, and the tracker state.
   ps2m_pkg::cfg_type   cfg_mirror;
   ps2m_pkg::phase_type trk_phase;
   logic [7:0] trk_header;
   logic [7:0] trk_x_byte;
   logic [7:0] trk_pos_x;
   logic [7:0] trk_pos_y;
   logic [2:0] trk_buttons;

   ps2m_pkg::rsp_type cursor_expect_q[$];
   int      error_count = 0;
   int      cycle_count = 0;
   int      burst_left  = 0;
   int      hold_requests = 0;
   int      holds_done    = 0;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Run limit in case the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Limit a position computed at full precision to 0..hi.
   function automatic logic [7:0] clamp_to_limit(input int v, input logic [7:0] hi);
      if (v < 0) return 8'd0;
      if (v > int'(hi)) return hi;
      return v[7:0];
   endfunction

   // Advance the packet tracker by one accepted byte. Returns 1 when the
   // byte completes a packet, with the new cursor in cursor.
   function automatic bit track_byte(input logic [7:0] b,
                                     output ps2m_pkg::rsp_type cursor);
      int dx;
      int dy;
      cursor = '0;
      if (!cfg_mirror.enable) return 0;
      case (trk_phase)
         ps2m_pkg::PHASE_X: begin
            trk_x_byte = b;
            trk_phase  = ps2m_pkg::PHASE_Y;
            return 0;
         end
         ps2m_pkg::PHASE_Y: begin
            trk_phase   = ps2m_pkg::PHASE_HEADER;
            trk_buttons = trk_header[2:0];
            dx = trk_header[ps2m_pkg::HDR_X_SIGN] ? int'(trk_x_byte) - 256
                                                  : int'(trk_x_byte);
            dy = trk_header[ps2m_pkg::HDR_Y_SIGN] ? int'(b) - 256 : int'(b);
            // Integer division truncates toward zero, as the mouse scaling wants.
            trk_pos_x = clamp_to_limit(int'(trk_pos_x) + dx / MOTION_DIV,
                                       cfg_mirror.x_max);
            trk_pos_y = clamp_to_limit(int'(trk_pos_y) - dy / MOTION_DIV,
                                       cfg_mirror.y_max);
            cursor.cursor_x = trk_pos_x;
            cursor.cursor_y = trk_pos_y;
            cursor.buttons  = trk_buttons;
            return 1;
         end
         default: begin
            // A header must carry the always-one bit; anything else resyncs.
            trk_phase = ps2m_pkg::PHASE_HEADER;
            if (b[ps2m_pkg::HDR_ALWAYS_ONE]) begin
               trk_header = b;
               trk_phase  = ps2m_pkg::PHASE_X;
            end
            return 0;
         end
      endcase
   endfunction

   task automatic report_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // Predict on every accepted byte and check every accepted cursor transaction.
   always @(posedge clock) begin : transaction_monitor
      ps2m_pkg::rsp_type cursor_want;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            if (track_byte(req_if.data_byte, cursor_want))
               cursor_expect_q.push_back(cursor_want);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (cursor_expect_q.size() == 0) begin
               $display({"%0t: unexpected cursor transaction: expected none, ",
                         "actual x=%0d y=%0d buttons=%0d"},
                        $time, rsp_if.cursor_x, rsp_if.cursor_y, rsp_if.buttons);
               error_count++;
            end else begin
               cursor_want = cursor_expect_q.pop_front();
               report_field("cursor_x", cursor_want.cursor_x, rsp_if.cursor_x);
               report_field("cursor_y", cursor_want.cursor_y, rsp_if.cursor_y);
               report_field("buttons",  cursor_want.buttons,  rsp_if.buttons);
            end
         end
      end
   end

   // Result ready: segments with their own stall rate, plus long hold-offs
   // on request, counted here.
   initial begin : rsp_ready_gen
      int seg_left;
      int stall_pct;
      int hold_left;
      seg_left  = 0;
      stall_pct = 0;
      hold_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (seg_left == 0) begin
            seg_left = $urandom_range(1, 40);
            case ($urandom_range(0, 3))
               0: stall_pct = 0;
               1: stall_pct = 25;
               2: stall_pct = 50;
               default: stall_pct = 90;
            endcase
         end
         seg_left--;
         if (hold_left == 0 && hold_requests != holds_done) begin
            hold_left = LONG_HOLD;
            holds_done++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // Offer one byte and wait for its transaction. Bytes go out in bursts of
   // random length with random gaps between them.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid     <= 1'b1;
      req_if.data_byte <= b;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic send_packet(input logic [7:0] hdr, input logic [7:0] xb,
                              input logic [7:0] yb);
      send_byte(hdr);
      send_byte(xb);
      send_byte(yb);
   endtask

   // Stop offering, wait for every pending cursor and let the pipeline empty.
   // The first edge lets the monitor record the last accepted byte.
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (cursor_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write, only ever done with the block idle.
   task automatic csr_write(input logic [ps2m_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [ps2m_pkg::CSR_DATA_WIDTH-1:0] value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         ps2m_pkg::CSR_ENABLE: cfg_mirror.enable = value[0];
         ps2m_pkg::CSR_X_MAX:  cfg_mirror.x_max  = value;
         ps2m_pkg::CSR_Y_MAX:  cfg_mirror.y_max  = value;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Bytes offered after reset, with decoding still off, must vanish.
   task automatic test_disabled_bytes();
      send_packet(8'h0F, 8'h55, 8'hAA);
      send_byte(8'h08);
      wait_idle();
   endtask

   // Field extremes, resync on bad headers, sign handling and clamping.
   task automatic test_directed_packets();
      csr_write(ps2m_pkg::CSR_ENABLE, 8'd1);
      send_packet(8'h08, 8'h00, 8'h00);
      send_byte(8'h00);
      send_byte(8'hF7);
      send_packet(8'h0F, 8'hFF, 8'hFF);
      send_packet(8'h38, 8'h00, 8'h00);
      // Small negative X truncates to zero movement.
      send_packet(8'h1A, 8'hFE, 8'h05);
      send_packet(8'h3C, 8'h01, 8'h01);
      send_packet(8'hC8, 8'h80, 8'h7F);
      wait_idle();
   endtask

   // Turning decoding off in the middle of a packet keeps its phase.
   task automatic test_enable_mid_packet();
      send_byte(8'h09);
      csr_write(ps2m_pkg::CSR_ENABLE, 8'd0);
      send_byte(8'h12);
      send_byte(8'h34);
      csr_write(ps2m_pkg::CSR_ENABLE, 8'd1);
      send_byte(8'h06);
      send_byte(8'h03);
      wait_idle();
   endtask

   // A cursor left beyond a lowered limit is clamped by the next packet.
   task automatic test_lowered_limits();
      csr_write(ps2m_pkg::CSR_X_MAX, 8'd255);
      csr_write(ps2m_pkg::CSR_Y_MAX, 8'd255);
      send_packet(8'h28, 8'hFF, 8'h00);
      send_packet(8'h28, 8'hFF, 8'h00);
      csr_write(ps2m_pkg::CSR_X_MAX, 8'd100);
      csr_write(ps2m_pkg::CSR_Y_MAX, 8'd50);
      send_packet(8'h08, 8'h00, 8'h00);
      csr_write(ps2m_pkg::CSR_X_MAX, 8'd0);
      csr_write(ps2m_pkg::CSR_Y_MAX, 8'd0);
      send_packet(8'h08, 8'h30, 8'hD0);
      wait_idle();
   endtask

   // Random motion: half the time full range, else a small step around zero.
   function automatic void rand_motion(output logic sign, output logic [7:0] low);
      int d;
      if ($urandom_range(0, 1) == 1) d = $urandom_range(0, 511) - 256;
      else d = $urandom_range(0, 16) - 8;
      sign = (d < 0);
      low  = d[7:0];
   endfunction

   // Mostly well-formed packets with random content, some stray bytes, under
   // a series of limit settings. One phase holds the receiver off for long.
   task automatic test_random_traffic();
      logic [7:0] limits_x[8];
      logic [7:0] limits_y[8];
      logic [7:0] hdr;
      logic [7:0] xb;
      logic [7:0] yb;
      logic       sx;
      logic       sy;
      int         sent;
      limits_x = '{8'd255, 8'd0, ps2m_pkg::X_MAX_RESET, 8'd255, 8'd0, 8'd1, 8'd0, 8'd0};
      limits_y = '{8'd255, 8'd0, ps2m_pkg::Y_MAX_RESET, 8'd0, 8'd255, 8'd1, 8'd0, 8'd0};
      limits_x[6] = 8'($urandom_range(0, 255));
      limits_y[6] = 8'($urandom_range(0, 255));
      limits_x[7] = 8'($urandom_range(0, 255));
      limits_y[7] = 8'($urandom_range(0, 255));
      for (int p = 0; p < 8; p++) begin
         csr_write(ps2m_pkg::CSR_X_MAX, limits_x[p]);
         csr_write(ps2m_pkg::CSR_Y_MAX, limits_y[p]);
         if (p == 2) hold_requests++;
         if (p == 4) begin
            csr_write(ps2m_pkg::CSR_ENABLE, 8'd0);
            repeat (16) send_byte(8'($urandom_range(0, 255)));
            csr_write(ps2m_pkg::CSR_ENABLE, 8'd1);
         end
         sent = 0;
         while (sent < 105) begin
            if ($urandom_range(0, 99) < 88) begin
               rand_motion(sx, xb);
               rand_motion(sy, yb);
               hdr = {2'($urandom_range(0, 3)), sy, sx, 1'b1, 3'($urandom_range(0, 7))};
               send_packet(hdr, xb, yb);
               sent += 3;
            end else begin
               send_byte(8'($urandom_range(0, 255)));
               sent++;
            end
         end
      end
      wait_idle();
   endtask

   // Main sequence.
   initial begin
      reset        <= 1'b1;
      csr_we       <= 1'b0;
      csr_index    <= ps2m_pkg::CSR_ENABLE;
      csr_wdata    <= '0;
      req_if.valid <= 1'b0;
      req_if.data_byte <= '0;
      cfg_mirror.enable = 1'b0;
      cfg_mirror.x_max  = ps2m_pkg::X_MAX_RESET;
      cfg_mirror.y_max  = ps2m_pkg::Y_MAX_RESET;
      trk_phase   = ps2m_pkg::PHASE_HEADER;
      trk_header  = '0;
      trk_x_byte  = '0;
      trk_pos_x   = ps2m_pkg::POS_X_RESET;
      trk_pos_y   = ps2m_pkg::POS_Y_RESET;
      trk_buttons = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_disabled_bytes();
      test_directed_packets();
      test_enable_mid_packet();
      test_lowered_limits();
      test_random_traffic();

      wait_idle();
      repeat (10) @(posedge clock);
      if (error_count == 0 && cursor_expect_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         if (cursor_expect_q.size() != 0)
            $display("%0t: %0d cursor transactions never arrived", $time,
                     cursor_expect_q.size());
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ----- ps2_mouse_packet_cursor_tracker.f -----
rtl/ps2m_pkg.sv
rtl/ps2m_if.sv
rtl/ps2m_core.sv
rtl/ps2_mouse_packet_cursor_tracker.sv
tb/sv/ps2_mouse_packet_cursor_tracker_tb.sv
